// ===== rtl/core/multi_queue_shortest_select_assert.svh =====
// Assertion macros for the multi-queue shortest-select block.
`ifndef MULTI_QUEUE_SHORTEST_SELECT_ASSERT_SVH
`define MULTI_QUEUE_SHORTEST_SELECT_ASSERT_SVH
`ifndef SYNTH
`define MQSS_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("mqss: property violated");
`define MQSS_ASSERT_RST(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("mqss: reset property violated");
`else
`define MQSS_ASSERT(label, prop)
`define MQSS_ASSERT_RST(label, prop)
`endif
`endif

// ===== rtl/core/mqss_pkg.sv =====
// Shared types, widths and defaults for the multi-queue shortest-select block.
`timescale 1ns / 1ps
package mqss_pkg;

  localparam int NUM_QUEUES_DEF  = 4;
  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int DATA_WIDTH_DEF  = 32;

  localparam int SEL_W      = 2;
  localparam int IO_DATA_W  = 32;
  localparam int SIZE_W     = 5;
  localparam int TOTAL_W    = 32;
  localparam int SHORTEST_W = 2;

  typedef enum logic {
    CMD_PUSH = 1'b0,
    CMD_POP  = 1'b1
  } cmd_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_ACCESS = 4'b0010,
    S_SELECT = 4'b0100,
    S_RESULT = 4'b1000
  } state_t;

  typedef struct packed {
    logic load;
    logic access;
    logic select;
  } dp_cmd_t;

endpackage

// ===== rtl/core/mqss_ram.sv =====
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps
module mqss_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// ===== rtl/core/mqss_ctrl.sv =====
// Controller state machine sequencing one queue operation at a time.
`timescale 1ns / 1ps
module mqss_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  output logic             done,
  output mqss_pkg::dp_cmd_t dp_cmd
);

  mqss_pkg::state_t state;
  mqss_pkg::state_t state_next;

  always_comb begin
    state_next = state;
    case (state)
      mqss_pkg::S_IDLE: begin
        if (start) begin
          state_next = mqss_pkg::S_ACCESS;
        end
      end
      mqss_pkg::S_ACCESS: begin
        state_next = mqss_pkg::S_SELECT;
      end
      mqss_pkg::S_SELECT: begin
        state_next = mqss_pkg::S_RESULT;
      end
      mqss_pkg::S_RESULT: begin
        state_next = mqss_pkg::S_IDLE;
      end
      default: begin
        state_next = mqss_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mqss_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy          = (state != mqss_pkg::S_IDLE);
  assign done          = (state == mqss_pkg::S_RESULT);
  assign dp_cmd.load   = start && (state == mqss_pkg::S_IDLE);
  assign dp_cmd.access = (state == mqss_pkg::S_ACCESS);
  assign dp_cmd.select = (state == mqss_pkg::S_SELECT);

endmodule

// ===== rtl/core/mqss_dp.sv =====
// Datapath: queue pointers, counts, totals, entry RAM and least-occupied tree.
`timescale 1ns / 1ps
module mqss_dp #(
  parameter int NUM_QUEUES  = mqss_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = mqss_pkg::QUEUE_DEPTH_DEF,
  parameter int DATA_WIDTH  = mqss_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  mqss_pkg::dp_cmd_t                 dp_cmd,
  input  logic                              cmd,
  input  logic [mqss_pkg::SEL_W-1:0]        queue_sel,
  input  logic [mqss_pkg::IO_DATA_W-1:0]    push_data,
  output logic                              ok,
  output logic [mqss_pkg::IO_DATA_W-1:0]    pop_data,
  output logic [mqss_pkg::SIZE_W-1:0]       queue_size,
  output logic                              crowded,
  output logic [mqss_pkg::TOTAL_W-1:0]      total_in,
  output logic [mqss_pkg::TOTAL_W-1:0]      total_out,
  output logic [mqss_pkg::SHORTEST_W-1:0]   shortest_queue
);

  localparam int PTR_W       = $clog2(QUEUE_DEPTH);
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int QIDX_W      = $clog2(NUM_QUEUES);
  localparam int ENTRIES     = NUM_QUEUES * QUEUE_DEPTH;
  localparam int ADDR_W      = $clog2(ENTRIES);
  localparam int LEAVES      = 1 << QIDX_W;
  localparam int NODES       = 2 * LEAVES - 1;
  localparam int CROWD_LIMIT = 8 * (QUEUE_DEPTH / 10);

  logic                         cmd_q;
  logic [mqss_pkg::SEL_W-1:0]   sel_q;
  logic [DATA_WIDTH-1:0]        data_q;

  logic [PTR_W-1:0]             head      [NUM_QUEUES];
  logic [PTR_W-1:0]             tail      [NUM_QUEUES];
  logic [CNT_W-1:0]             occ       [NUM_QUEUES];
  logic [mqss_pkg::TOTAL_W-1:0] push_tot  [NUM_QUEUES];
  logic [mqss_pkg::TOTAL_W-1:0] pop_tot   [NUM_QUEUES];

  logic                         pop_ok;
  logic [mqss_pkg::SHORTEST_W-1:0] shortest;

  logic [63:0]                  push_ext;
  logic [63:0]                  rd_ext;
  logic                         sel_valid;
  logic [QIDX_W-1:0]            q;
  logic [CNT_W-1:0]             cur_occ;
  logic                         do_push;
  logic                         do_pop;
  logic [CNT_W-1:0]             occ_next;
  logic [PTR_W-1:0]             ptr;
  logic [PTR_W-1:0]             ptr_next;
  logic [mqss_pkg::TOTAL_W-1:0] push_tot_next;
  logic [mqss_pkg::TOTAL_W-1:0] pop_tot_next;
  logic [ADDR_W-1:0]            ram_addr;
  logic [DATA_WIDTH-1:0]        ram_rdata;
  logic                         ram_we;

  logic [CNT_W-1:0]             tree_cnt [NODES];
  logic [QIDX_W-1:0]            tree_idx [NODES];

  assign push_ext  = 64'(push_data);
  assign rd_ext    = 64'(ram_rdata);
  assign sel_valid = (32'(sel_q) < NUM_QUEUES);
  assign q         = QIDX_W'(sel_q);
  assign cur_occ   = occ[q];

  always_comb begin
    do_push = 1'b0;
    do_pop  = 1'b0;
    if (sel_valid) begin
      if (cmd_q == mqss_pkg::CMD_PUSH) begin
        do_push = (cur_occ != CNT_W'(QUEUE_DEPTH));
      end else begin
        do_pop = (cur_occ != '0);
      end
    end
    occ_next      = cur_occ;
    push_tot_next = push_tot[q];
    pop_tot_next  = pop_tot[q];
    if (do_push) begin
      occ_next      = cur_occ + CNT_W'(1);
      push_tot_next = push_tot[q] + mqss_pkg::TOTAL_W'(1);
    end
    if (do_pop) begin
      occ_next     = cur_occ - CNT_W'(1);
      pop_tot_next = pop_tot[q] + mqss_pkg::TOTAL_W'(1);
    end
    ptr = (cmd_q == mqss_pkg::CMD_PUSH) ? tail[q] : head[q];
    if (32'(ptr) == QUEUE_DEPTH - 1) begin
      ptr_next = '0;
    end else begin
      ptr_next = ptr + PTR_W'(1);
    end
  end

  assign ram_addr = ADDR_W'(q) * ADDR_W'(QUEUE_DEPTH) + ADDR_W'(ptr);
  assign ram_we   = dp_cmd.access && do_push;

  mqss_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (ENTRIES)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (data_q),
    .rdata (ram_rdata)
  );

  // Tournament tree over the counts; the left child wins ties so the lowest
  // index is kept, and unused leaves carry the largest count.
  always_comb begin
    for (int i = 0; i < LEAVES; i++) begin
      tree_idx[LEAVES-1+i] = QIDX_W'(i);
      if (i < NUM_QUEUES) begin
        tree_cnt[LEAVES-1+i] = occ[i];
      end else begin
        tree_cnt[LEAVES-1+i] = '1;
      end
    end
    for (int n = LEAVES - 2; n >= 0; n--) begin
      if (tree_cnt[2*n+2] < tree_cnt[2*n+1]) begin
        tree_cnt[n] = tree_cnt[2*n+2];
        tree_idx[n] = tree_idx[2*n+2];
      end else begin
        tree_cnt[n] = tree_cnt[2*n+1];
        tree_idx[n] = tree_idx[2*n+1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (dp_cmd.load) begin
      cmd_q  <= cmd;
      sel_q  <= queue_sel;
      data_q <= push_ext[DATA_WIDTH-1:0];
    end
    if (dp_cmd.access) begin
      ok         <= do_push || do_pop;
      pop_ok     <= do_pop;
      queue_size <= sel_valid ? mqss_pkg::SIZE_W'(occ_next) : '0;
      crowded    <= sel_valid && (32'(occ_next) > CROWD_LIMIT);
      total_in   <= sel_valid ? push_tot_next : '0;
      total_out  <= sel_valid ? pop_tot_next : '0;
    end
    if (dp_cmd.select) begin
      pop_data <= pop_ok ? rd_ext[mqss_pkg::IO_DATA_W-1:0] : '0;
      shortest <= mqss_pkg::SHORTEST_W'(tree_idx[0]);
    end
  end

  assign shortest_queue = shortest;

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < NUM_QUEUES; i++) begin
        head[i]     <= '0;
        tail[i]     <= '0;
        occ[i]      <= '0;
        push_tot[i] <= '0;
        pop_tot[i]  <= '0;
      end
    end else if (dp_cmd.access) begin
      occ[q]      <= occ_next;
      push_tot[q] <= push_tot_next;
      pop_tot[q]  <= pop_tot_next;
      if (do_push) begin
        tail[q] <= ptr_next;
      end
      if (do_pop) begin
        head[q] <= ptr_next;
      end
    end
  end

endmodule

// ===== rtl/core/multi_queue_shortest_select.sv =====
// Top level of the multi-queue bank with least-occupied queue select.
//
//   Channel   Handshake        Ports
//   --------  ---------------  ------------------------------------------------
//   command   start, busy      cmd, queue_sel, push_data
//   result    done (strobe)    ok, pop_data, queue_size, crowded, total_in,
//                              total_out, shortest_queue
//
// An item is taken when start is high and busy is low; busy then stays high
// through the access, select and result states, and the result is strobed on
// done in the result state, and a new item is taken only after that state.
// The RAM read is registered in access, the least-occupied tree in select.
// Reset clears the pointers, counts and totals at once; entries are not cleared.
// The result is shown for one cycle only and cannot be held off.
`timescale 1ns / 1ps
`include "multi_queue_shortest_select_assert.svh"
module multi_queue_shortest_select #(
  parameter int NUM_QUEUES  = mqss_pkg::NUM_QUEUES_DEF,
  parameter int QUEUE_DEPTH = mqss_pkg::QUEUE_DEPTH_DEF,
  parameter int DATA_WIDTH  = mqss_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic                              cmd,
  input  logic [mqss_pkg::SEL_W-1:0]        queue_sel,
  input  logic [mqss_pkg::IO_DATA_W-1:0]    push_data,
  output logic                              done,
  output logic                              ok,
  output logic [mqss_pkg::IO_DATA_W-1:0]    pop_data,
  output logic [mqss_pkg::SIZE_W-1:0]       queue_size,
  output logic                              crowded,
  output logic [mqss_pkg::TOTAL_W-1:0]      total_in,
  output logic [mqss_pkg::TOTAL_W-1:0]      total_out,
  output logic [mqss_pkg::SHORTEST_W-1:0]   shortest_queue
);

  mqss_pkg::dp_cmd_t dp_cmd;

  mqss_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .dp_cmd (dp_cmd)
  );

  mqss_dp #(
    .NUM_QUEUES  (NUM_QUEUES),
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .DATA_WIDTH  (DATA_WIDTH)
  ) u_dp (
    .clk            (clk),
    .rst            (rst),
    .dp_cmd         (dp_cmd),
    .cmd            (cmd),
    .queue_sel      (queue_sel),
    .push_data      (push_data),
    .ok             (ok),
    .pop_data       (pop_data),
    .queue_size     (queue_size),
    .crowded        (crowded),
    .total_in       (total_in),
    .total_out      (total_out),
    .shortest_queue (shortest_queue)
  );

  `MQSS_ASSERT(a_item_latency, start && !busy |-> ##3 done)
  `MQSS_ASSERT(a_done_single, done |=> !done)
  `MQSS_ASSERT(a_fail_no_data, done && !ok |-> pop_data == '0)
  `MQSS_ASSERT_RST(a_idle_after_reset, $past(rst) |-> !busy && !done)

endmodule
